@@ rtl/vau_pkg.sv @@
// Shared types, opcodes and constants of the 3D vector arithmetic unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package vau_pkg;

   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int MAG_BITS    = WORD_BITS;          // |x| up to 2^(W-1)
   localparam int PROD_BITS   = 2 * MAG_BITS;
   localparam int ACC_BITS    = PROD_BITS + 2;      // sum of three signed products
   localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] OP_ADD       = 4'd0;
   localparam logic [3:0] OP_SUB       = 4'd1;
   localparam logic [3:0] OP_SCALE     = 4'd2;
   localparam logic [3:0] OP_DIVIDE    = 4'd3;
   localparam logic [3:0] OP_DOT       = 4'd4;
   localparam logic [3:0] OP_CROSS     = 4'd5;
   localparam logic [3:0] OP_NORMALIZE = 4'd6;
   localparam logic [3:0] OP_MAGNITUDE = 4'd7;
   localparam logic [3:0] OP_EQUAL     = 4'd8;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_DIV_ZERO  = 2'd1;
   localparam logic [1:0] ERR_ZERO_NORM = 2'd2;

   typedef struct packed {
      logic [3:0]                  opcode;
      logic signed [WORD_BITS-1:0] a_x;
      logic signed [WORD_BITS-1:0] a_y;
      logic signed [WORD_BITS-1:0] a_z;
      logic signed [WORD_BITS-1:0] b_x;
      logic signed [WORD_BITS-1:0] b_y;
      logic signed [WORD_BITS-1:0] b_z;
      logic signed [WORD_BITS-1:0] scale_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_x;
      logic signed [WORD_BITS-1:0] res_y;
      logic signed [WORD_BITS-1:0] res_z;
      logic signed [WORD_BITS-1:0] res_scalar;
      logic                        is_equal;
      logic [1:0]                  error_code;
      logic                        overflow;
   } rsp_type;

   // Classified item as queued between front and back.
   typedef struct packed {
      logic [3:0]                opcode;
      logic [2:0]                a_neg;
      logic [2:0][MAG_BITS-1:0]  a_mag;
      logic [2:0]                b_neg;
      logic [2:0][MAG_BITS-1:0]  b_mag;
      logic                      s_neg;
      logic [MAG_BITS-1:0]       s_mag;
      logic                      is_equal;
      logic                      s_zero;
   } work_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 ovf;
   } sat_type;

   // Sign and magnitude to a clamped two's complement word.
   function automatic sat_type saturate(input logic neg, input logic [ACC_BITS-1:0] mag);
      sat_type              r;
      logic [ACC_BITS-1:0]  lim;
      lim   = ACC_BITS'({(WORD_BITS-1){1'b1}});
      r.ovf = 1'b0;
      if (!neg) begin
         if (mag > lim) begin
            r.value = {1'b0, {(WORD_BITS-1){1'b1}}};
            r.ovf   = 1'b1;
         end else begin
            r.value = mag[WORD_BITS-1:0];
         end
      end else begin
         if (mag > lim + ACC_BITS'(1)) begin
            r.value = {1'b1, {(WORD_BITS-1){1'b0}}};
            r.ovf   = 1'b1;
         end else begin
            r.value = -mag[WORD_BITS-1:0];
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/vau_front.sv @@
// Front end: splits the request words into sign and magnitude and
// precomputes the equality and zero-divisor flags. Uses vau_pkg.
`timescale 1ns / 1ps
module vau_front import vau_pkg::*; (
   input  req_type  req_data,
   output work_type work
);

   function automatic logic [MAG_BITS-1:0] mag_of(input logic [WORD_BITS-1:0] x);
      return x[WORD_BITS-1] ? -x : x;
   endfunction

   always_comb begin
      work.opcode   = req_data.opcode;
      work.a_neg    = {req_data.a_z[WORD_BITS-1], req_data.a_y[WORD_BITS-1],
                       req_data.a_x[WORD_BITS-1]};
      work.b_neg    = {req_data.b_z[WORD_BITS-1], req_data.b_y[WORD_BITS-1],
                       req_data.b_x[WORD_BITS-1]};
      work.a_mag[0] = mag_of(req_data.a_x);
      work.a_mag[1] = mag_of(req_data.a_y);
      work.a_mag[2] = mag_of(req_data.a_z);
      work.b_mag[0] = mag_of(req_data.b_x);
      work.b_mag[1] = mag_of(req_data.b_y);
      work.b_mag[2] = mag_of(req_data.b_z);
      work.s_neg    = req_data.scale_value[WORD_BITS-1];
      work.s_mag    = mag_of(req_data.scale_value);
      work.s_zero   = (req_data.scale_value == '0);
      work.is_equal = (req_data.a_x == req_data.b_x) && (req_data.a_y == req_data.b_y) &&
                      (req_data.a_z == req_data.b_z);
   end

endmodule

@@ rtl/vau_fifo.sv @@
// Short queue of classified items between front and back.
// Uses work_type from vau_pkg.
`timescale 1ns / 1ps
module vau_fifo import vau_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   work_type              mem_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, rd_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   assign full  = (cnt_ff == CNT_BITS'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/vau_back.sv @@
// Back end: sequencer with one multiplier shared by all MAC terms, a bit-serial
// square root with its own squarer and a restoring divider. Uses vau_pkg.
`timescale 1ns / 1ps
module vau_back import vau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     empty,
   input  work_type head,
   output logic     pop,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADDSUB, ST_MAC, ST_FIN, ST_SQRT, ST_DIV, ST_DONE
   } state_type;

   localparam int BIT_BITS  = $clog2(MAG_BITS);
   localparam int STEP_BITS = $clog2(NUM_BITS);

   state_type                   state_ff;
   work_type                    work_ff;
   rsp_type                     rsp_ff;
   logic                        valid_ff;
   logic [1:0]                  ci_ff, t_ff;
   logic signed [ACC_BITS-1:0]  acc_ff;
   logic [MAG_BITS-1:0]         root_ff, div_ff, rem_ff;
   logic [BIT_BITS-1:0]         bit_ff;
   logic [STEP_BITS-1:0]        step_ff;
   logic [NUM_BITS-1:0]         num_ff, quo_ff;

   // fields known at dispatch
   rsp_type                     rsp_init;
   // term selection
   logic [1:0]                  idx_a, idx_b;
   logic                        use_s, square, term_neg, term_last, comp_last;
   logic [MAG_BITS-1:0]         fa, fb;
   logic [PROD_BITS-1:0]        prod;
   logic signed [ACC_BITS-1:0]  acc_base, acc_sum;
   // finish of a MAC component
   logic                        acc_neg;
   logic [ACC_BITS-1:0]         acc_abs;
   sat_type                     fin;
   // sqrt step
   logic [MAG_BITS-1:0]         cand, root_nx;
   logic [PROD_BITS-1:0]        cand_sq;
   sat_type                     mag_sat;
   // divider step
   logic [MAG_BITS:0]           rem_sh;
   logic                        ge, div_neg;
   logic [MAG_BITS-1:0]         rem_nx;
   logic [NUM_BITS-1:0]         quo_nx;
   sat_type                     div_sat;
   // add / sub
   logic signed [WORD_BITS+1:0] av [3], bv [3], sv [3];
   sat_type                     as_sat [3];

   always_comb begin
      rsp_init = '0;
      if ((head.opcode == OP_DIVIDE) && head.s_zero) begin
         rsp_init.error_code = ERR_DIV_ZERO;
      end
      if (head.opcode == OP_EQUAL) begin
         rsp_init.is_equal = head.is_equal;
      end
   end

   always_comb begin
      idx_a     = 2'd0;
      idx_b     = 2'd0;
      use_s     = 1'b0;
      square    = 1'b0;
      term_neg  = 1'b0;
      term_last = 1'b1;
      comp_last = 1'b1;
      case (work_ff.opcode)
         OP_SCALE: begin
            idx_a     = ci_ff;
            use_s     = 1'b1;
            term_neg  = work_ff.a_neg[ci_ff] ^ work_ff.s_neg;
            comp_last = (ci_ff == 2'd2);
         end
         OP_DOT: begin
            idx_a     = t_ff;
            idx_b     = t_ff;
            term_neg  = work_ff.a_neg[t_ff] ^ work_ff.b_neg[t_ff];
            term_last = (t_ff == 2'd2);
         end
         OP_CROSS: begin
            case ({ci_ff, t_ff[0]})
               3'b000:  begin idx_a = 2'd1; idx_b = 2'd2; end
               3'b001:  begin idx_a = 2'd2; idx_b = 2'd1; end
               3'b010:  begin idx_a = 2'd2; idx_b = 2'd0; end
               3'b011:  begin idx_a = 2'd0; idx_b = 2'd2; end
               3'b100:  begin idx_a = 2'd0; idx_b = 2'd1; end
               3'b101:  begin idx_a = 2'd1; idx_b = 2'd0; end
               default: begin idx_a = 2'd0; idx_b = 2'd0; end
            endcase
            term_neg  = work_ff.a_neg[idx_a] ^ work_ff.b_neg[idx_b] ^ t_ff[0];
            term_last = t_ff[0];
            comp_last = (ci_ff == 2'd2);
         end
         OP_NORMALIZE, OP_MAGNITUDE: begin
            idx_a     = t_ff;
            square    = 1'b1;
            term_last = (t_ff == 2'd2);
         end
         default: begin
            idx_a = 2'd0;
         end
      endcase
      fa = work_ff.a_mag[idx_a];
      fb = use_s ? work_ff.s_mag : (square ? work_ff.a_mag[idx_a] : work_ff.b_mag[idx_b]);
   end

   assign prod     = fa * fb;
   assign acc_base = (t_ff == 2'd0) ? '0 : acc_ff;
   assign acc_sum  = term_neg ? acc_base - $signed({2'b00, prod})
                              : acc_base + $signed({2'b00, prod});

   assign acc_neg  = acc_ff[ACC_BITS-1];
   assign acc_abs  = acc_neg ? -acc_ff : acc_ff;
   assign fin      = saturate(acc_neg, acc_abs >> FRAC_BITS);

   assign cand     = root_ff | (MAG_BITS'(1) << bit_ff);
   assign cand_sq  = cand * cand;
   assign root_nx  = (cand_sq <= acc_ff[PROD_BITS-1:0]) ? cand : root_ff;
   assign mag_sat  = saturate(1'b0, ACC_BITS'(root_nx));

   assign rem_sh   = {rem_ff, num_ff[NUM_BITS-1]};
   assign ge       = (rem_sh >= {1'b0, div_ff});
   assign rem_nx   = ge ? MAG_BITS'(rem_sh - {1'b0, div_ff}) : rem_sh[MAG_BITS-1:0];
   assign quo_nx   = {quo_ff[NUM_BITS-2:0], ge};
   assign div_neg  = (work_ff.opcode == OP_DIVIDE) ? (work_ff.a_neg[ci_ff] ^ work_ff.s_neg)
                                                   : work_ff.a_neg[ci_ff];
   assign div_sat  = saturate(div_neg, ACC_BITS'(quo_nx));

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         av[i] = work_ff.a_neg[i] ? -$signed({2'b00, work_ff.a_mag[i]})
                                  : $signed({2'b00, work_ff.a_mag[i]});
         bv[i] = work_ff.b_neg[i] ? -$signed({2'b00, work_ff.b_mag[i]})
                                  : $signed({2'b00, work_ff.b_mag[i]});
         sv[i] = (work_ff.opcode == OP_SUB) ? av[i] - bv[i] : av[i] + bv[i];
         as_sat[i] = saturate(sv[i][WORD_BITS+1],
                              ACC_BITS'(sv[i][WORD_BITS+1] ? -sv[i] : sv[i]));
      end
   end

   assign pop       = (state_ff == ST_IDLE) && !empty;
   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (state_ff == ST_DONE);
         case (state_ff)
            ST_IDLE: begin
               if (!empty) begin
                  work_ff <= head;
                  rsp_ff  <= rsp_init;
                  ci_ff   <= 2'd0;
                  t_ff    <= 2'd0;
                  case (head.opcode)
                     OP_ADD, OP_SUB: state_ff <= ST_ADDSUB;
                     OP_SCALE, OP_DOT, OP_CROSS, OP_NORMALIZE, OP_MAGNITUDE:
                        state_ff <= ST_MAC;
                     OP_DIVIDE: begin
                        if (head.s_zero) begin
                           state_ff <= ST_DONE;
                        end else begin
                           div_ff   <= head.s_mag;
                           num_ff   <= NUM_BITS'(head.a_mag[0]) << FRAC_BITS;
                           rem_ff   <= '0;
                           quo_ff   <= '0;
                           step_ff  <= STEP_BITS'(NUM_BITS - 1);
                           state_ff <= ST_DIV;
                        end
                     end
                     OP_EQUAL: state_ff <= ST_DONE;
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_ADDSUB: begin
               rsp_ff.res_x    <= as_sat[0].value;
               rsp_ff.res_y    <= as_sat[1].value;
               rsp_ff.res_z    <= as_sat[2].value;
               rsp_ff.overflow <= as_sat[0].ovf | as_sat[1].ovf | as_sat[2].ovf;
               state_ff        <= ST_DONE;
            end
            ST_MAC: begin
               acc_ff <= acc_sum;
               t_ff   <= t_ff + 2'd1;
               if (term_last) begin
                  if (square) begin
                     root_ff  <= '0;
                     bit_ff   <= BIT_BITS'(MAG_BITS - 1);
                     state_ff <= ST_SQRT;
                  end else begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_FIN: begin
               t_ff            <= 2'd0;
               rsp_ff.overflow <= rsp_ff.overflow | fin.ovf;
               if (work_ff.opcode == OP_DOT) begin
                  rsp_ff.res_scalar <= fin.value;
               end else begin
                  case (ci_ff)
                     2'd0:    rsp_ff.res_x <= fin.value;
                     2'd1:    rsp_ff.res_y <= fin.value;
                     default: rsp_ff.res_z <= fin.value;
                  endcase
               end
               if (comp_last) begin
                  state_ff <= ST_DONE;
               end else begin
                  ci_ff    <= ci_ff + 2'd1;
                  state_ff <= ST_MAC;
               end
            end
            ST_SQRT: begin
               root_ff <= root_nx;
               bit_ff  <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  if (work_ff.opcode == OP_MAGNITUDE) begin
                     rsp_ff.res_scalar <= mag_sat.value;
                     rsp_ff.overflow   <= mag_sat.ovf;
                     state_ff          <= ST_DONE;
                  end else if (root_nx == '0) begin
                     rsp_ff.error_code <= ERR_ZERO_NORM;
                     state_ff          <= ST_DONE;
                  end else begin
                     div_ff   <= root_nx;
                     ci_ff    <= 2'd0;
                     num_ff   <= NUM_BITS'(work_ff.a_mag[0]) << FRAC_BITS;
                     rem_ff   <= '0;
                     quo_ff   <= '0;
                     step_ff  <= STEP_BITS'(NUM_BITS - 1);
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (step_ff != '0) begin
                  rem_ff  <= rem_nx;
                  quo_ff  <= quo_nx;
                  num_ff  <= num_ff << 1;
                  step_ff <= step_ff - 1'b1;
               end else begin
                  rsp_ff.overflow <= rsp_ff.overflow | div_sat.ovf;
                  case (ci_ff)
                     2'd0:    rsp_ff.res_x <= div_sat.value;
                     2'd1:    rsp_ff.res_y <= div_sat.value;
                     default: rsp_ff.res_z <= div_sat.value;
                  endcase
                  if (ci_ff == 2'd2) begin
                     state_ff <= ST_DONE;
                  end else begin
                     ci_ff   <= ci_ff + 2'd1;
                     num_ff  <= NUM_BITS'(work_ff.a_mag[ci_ff + 2'd1]) << FRAC_BITS;
                     rem_ff  <= '0;
                     quo_ff  <= '0;
                     step_ff <= STEP_BITS'(NUM_BITS - 1);
                  end
               end
            end
            ST_DONE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/vector3_arithmetic_unit_top.sv @@
// 3D vector ALU on signed Q16.16 words: front classifier, item queue, back sequencer.
// The back sequencer works on one item at a time (shared multiplier, bit-serial sqrt and
// divider) and pops the next only once back in idle; start is taken while the queue has room.
// Synchronous active-high reset empties the queue and idles the sequencer; no stall on rsp.
`timescale 1ns / 1ps
module vector3_arithmetic_unit_top import vau_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   // request channel: transfer when start && !busy
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   // result channel: one-cycle strobe, never stalled
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   work_type front_work, head_work;
   logic     q_full, q_empty, q_pop, q_push;

   // Front is combinational (signs, magnitudes and flags); the transfer goes straight
   // into the queue, so busy is simply queue full.
   vau_front u_front (
      .req_data (req_data),
      .work     (front_work)
   );

   assign q_push = start && !q_full;
   assign busy   = q_full;

   vau_fifo #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_work),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head_work)
   );

   // Back pops one item at a time and strobes its result from a register.
   vau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (head_work),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
